[rtl/fsfs_pkg.sv]
// Shared types, scan mode codes and the conversion letter table of the format string scanner.
package fsfs_pkg;

  localparam int MODE_W = 3;

  localparam logic [MODE_W-1:0] MODE_IDLE   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PCT    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FLAGS  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DIGITS = 3'd3;
  localparam logic [MODE_W-1:0] MODE_LONG   = 3'd4;

  localparam logic [31:0] WIDTH_BIT = 32'h4000_0000;
  localparam logic [1:0]  LEVEL_MINI = 2'd1;
  localparam logic [1:0]  LEVEL_STD  = 2'd2;

  localparam logic [7:0] CHR_PCT   = 8'h25;
  localparam logic [7:0] CHR_MINUS = 8'h2D;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;
  localparam logic [7:0] CHR_PLUS  = 8'h2B;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_STAR  = 8'h2A;
  localparam logic [7:0] CHR_DOT   = 8'h2E;
  localparam logic [7:0] CHR_ELL   = 8'h6C;
  localparam logic [7:0] CHR_UC_A  = 8'h41;
  localparam logic [7:0] CHR_UC_Z  = 8'h5A;
  localparam logic [7:0] CHR_LC_A  = 8'h61;
  localparam logic [7:0] CHR_LC_Z  = 8'h7A;

  typedef struct packed {
    logic        match;
    logic [1:0]  lvl;
    logic [31:0] short_mask;
    logic [31:0] long_mask;
  } conv_entry_t;

  typedef struct packed {
    logic        is_last;
    logic        is_pct;
    logic        is_flag;
    logic        is_digit;
    logic        is_dot;
    logic        is_letter;
    logic        is_ell;
    conv_entry_t conv;
  } char_class_t;

  function automatic conv_entry_t conv_lookup(input logic [7:0] c);
    conv_entry_t e;
    e = '{match: 1'b1, lvl: 2'd0, short_mask: 32'h0, long_mask: 32'h0};
    case (c)
      8'h64: begin e.lvl = 2'd1; e.short_mask = 32'h0000_0001; e.long_mask = 32'h0000_1000; end
      8'h75: begin e.lvl = 2'd1; e.short_mask = 32'h0000_0002; e.long_mask = 32'h0000_2000; end
      8'h78: begin e.lvl = 2'd2; e.short_mask = 32'h0000_0004; e.long_mask = 32'h0000_4000; end
      8'h58: begin e.lvl = 2'd2; e.short_mask = 32'h0000_0008; e.long_mask = 32'h0000_8000; end
      8'h6F: begin e.lvl = 2'd2; e.short_mask = 32'h0000_0010; e.long_mask = 32'h0001_0000; end
      8'h6E: begin e.lvl = 2'd2; e.short_mask = 32'h0000_0020; e.long_mask = 32'h0002_0000; end
      8'h69: begin e.lvl = 2'd2; e.short_mask = 32'h0000_0040; e.long_mask = 32'h0004_0000; end
      8'h70: begin e.lvl = 2'd2; e.short_mask = 32'h0000_0080; e.long_mask = 32'h0008_0000; end
      8'h42: begin e.lvl = 2'd2; e.short_mask = 32'h0000_0100; e.long_mask = 32'h0010_0000; end
      8'h73: begin e.lvl = 2'd1; e.short_mask = 32'h0000_0200; end
      8'h63: begin e.lvl = 2'd1; e.short_mask = 32'h0000_0400; end
      8'h61: begin e.lvl = 2'd0; e.short_mask = 32'h0040_0000; end
      8'h41: begin e.lvl = 2'd0; e.short_mask = 32'h0080_0000; end
      8'h65: begin e.lvl = 2'd3; e.short_mask = 32'h0100_0000; e.long_mask = 32'h0100_0000; end
      8'h45: begin e.lvl = 2'd3; e.short_mask = 32'h0200_0000; e.long_mask = 32'h0200_0000; end
      8'h66: begin e.lvl = 2'd3; e.short_mask = 32'h0400_0000; e.long_mask = 32'h0400_0000; end
      8'h46: begin e.lvl = 2'd3; e.short_mask = 32'h0800_0000; e.long_mask = 32'h0800_0000; end
      8'h67: begin e.lvl = 2'd3; e.short_mask = 32'h1000_0000; e.long_mask = 32'h1000_0000; end
      8'h47: begin e.lvl = 2'd3; e.short_mask = 32'h2000_0000; e.long_mask = 32'h2000_0000; end
      default: e.match = 1'b0;
    endcase
    return e;
  endfunction

endpackage

[rtl/fsfs_if.sv]
// Valid/ready channel interfaces for format bytes and scan results.
interface fsfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] format_char;
  logic       is_last;

  modport source (output valid, output format_char, output is_last, input ready);
  modport sink (input valid, input format_char, input is_last, output ready);
endinterface

interface fsfs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] option_mask;
  logic [1:0]  level;

  modport source (output valid, output option_mask, output level, input ready);
  modport sink (input valid, input option_mask, input level, output ready);
endinterface

[rtl/fsfs_front.sv]
// Front end: classifies each format byte and looks it up in the conversion table.
module fsfs_front (
  input  logic [7:0]            format_char,
  input  logic                  is_last,
  output fsfs_pkg::char_class_t cls
);

  always_comb begin
    cls.is_last   = is_last;
    cls.is_pct    = (format_char == fsfs_pkg::CHR_PCT);
    cls.is_flag   = (format_char == fsfs_pkg::CHR_MINUS) || (format_char == fsfs_pkg::CHR_ZERO) ||
                    (format_char == fsfs_pkg::CHR_PLUS) || (format_char == fsfs_pkg::CHR_SPACE) ||
                    (format_char == fsfs_pkg::CHR_STAR) || (format_char == fsfs_pkg::CHR_DOT);
    cls.is_digit  = (format_char >= fsfs_pkg::CHR_ZERO) && (format_char <= fsfs_pkg::CHR_NINE);
    cls.is_dot    = (format_char == fsfs_pkg::CHR_DOT);
    cls.is_letter = ((format_char >= fsfs_pkg::CHR_UC_A) && (format_char <= fsfs_pkg::CHR_UC_Z)) ||
                    ((format_char >= fsfs_pkg::CHR_LC_A) && (format_char <= fsfs_pkg::CHR_LC_Z));
    cls.is_ell    = (format_char == fsfs_pkg::CHR_ELL);
    cls.conv      = fsfs_pkg::conv_lookup(format_char);
  end

endmodule

[rtl/fsfs_queue.sv]
// Small FIFO of classified bytes between the front end and the back end.
module fsfs_queue #(
  parameter int DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  fsfs_pkg::char_class_t push_data,
  output logic                  full,
  input  logic                  pop,
  output fsfs_pkg::char_class_t pop_data,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  fsfs_pkg::char_class_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push_en, pop_en;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign push_en  = push && !full;
  assign pop_en   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_en) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_en) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push_en, pop_en})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/fsfs_back.sv]
// Back end: specifier state machine, mask and level accumulation, and the result register.
module fsfs_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  item_valid,
  input  fsfs_pkg::char_class_t cls,
  output logic                  item_pop,
  output logic                  res_valid,
  input  logic                  res_ready,
  output logic [31:0]           res_mask,
  output logic [1:0]            res_level
);

  logic [fsfs_pkg::MODE_W-1:0] mode_r, mode_nxt;
  logic [31:0]                 mask_r, mask_nxt;
  logic [1:0]                  level_r, level_nxt;
  logic                        res_valid_r, res_valid_nxt;
  logic [31:0]                 res_mask_r;
  logic [1:0]                  res_level_r;
  logic                        do_len, do_conv, conv_long;

  assign item_pop  = item_valid && (!cls.is_last || !res_valid_r || res_ready);
  assign res_valid = res_valid_r;
  assign res_mask  = res_mask_r;
  assign res_level = res_level_r;

  always_comb begin
    mode_nxt  = mode_r;
    mask_nxt  = mask_r;
    level_nxt = level_r;
    do_len    = 1'b0;
    do_conv   = 1'b0;
    conv_long = 1'b0;

    case (mode_r)
      fsfs_pkg::MODE_PCT: begin
        if (cls.is_flag || cls.is_digit) begin
          if (level_nxt < fsfs_pkg::LEVEL_STD) begin
            level_nxt = fsfs_pkg::LEVEL_STD;
          end
          mask_nxt = mask_nxt | fsfs_pkg::WIDTH_BIT;
          mode_nxt = cls.is_flag ? fsfs_pkg::MODE_FLAGS : fsfs_pkg::MODE_DIGITS;
        end else begin
          do_len = 1'b1;
        end
      end
      fsfs_pkg::MODE_FLAGS: begin
        do_len = cls.is_letter;
      end
      fsfs_pkg::MODE_DIGITS: begin
        do_len = !(cls.is_digit || cls.is_dot);
      end
      fsfs_pkg::MODE_LONG: begin
        do_conv   = 1'b1;
        conv_long = 1'b1;
      end
      default: begin
        mode_nxt = cls.is_pct ? fsfs_pkg::MODE_PCT : fsfs_pkg::MODE_IDLE;
      end
    endcase

    if (do_len) begin
      if (cls.is_ell) begin
        if (level_nxt < fsfs_pkg::LEVEL_STD) begin
          level_nxt = fsfs_pkg::LEVEL_STD;
        end
        mode_nxt = fsfs_pkg::MODE_LONG;
      end else begin
        do_conv = 1'b1;
      end
    end

    if (do_conv) begin
      if (cls.conv.match) begin
        if (level_nxt < cls.conv.lvl) begin
          level_nxt = cls.conv.lvl;
        end
        mask_nxt = mask_nxt | (conv_long ? cls.conv.long_mask : cls.conv.short_mask);
      end
      mode_nxt = cls.is_pct ? fsfs_pkg::MODE_PCT : fsfs_pkg::MODE_IDLE;
    end
  end

  always_comb begin
    res_valid_nxt = res_valid_r;
    if (res_valid_r && res_ready) begin
      res_valid_nxt = 1'b0;
    end
    if (item_pop && cls.is_last) begin
      res_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= fsfs_pkg::MODE_IDLE;
      mask_r      <= '0;
      level_r     <= fsfs_pkg::LEVEL_MINI;
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= res_valid_nxt;
      if (item_pop) begin
        if (cls.is_last) begin
          mode_r  <= fsfs_pkg::MODE_IDLE;
          mask_r  <= '0;
          level_r <= fsfs_pkg::LEVEL_MINI;
        end else begin
          mode_r  <= mode_nxt;
          mask_r  <= mask_nxt;
          level_r <= level_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop && cls.is_last) begin
      res_mask_r  <= mask_nxt;
      res_level_r <= level_nxt;
    end
  end

endmodule

[rtl/format_string_feature_scanner_top.sv]
// Top level of the format string feature scanner.
// The scanner takes one byte of a printf-style format string per cycle while
// its queue has room and, on the byte marked last, delivers one result with
// the OR of the conversion masks it met and the formatter level it needs;
// nothing is delivered for the other bytes. A byte is classified on entry and
// stored in a small queue of QUEUE_DEPTH entries, and the specifier state
// machine takes one byte per cycle from that queue, so the sustained rate is
// one byte per clock unless a waiting result holds up a last byte. The result
// is registered as its last byte leaves the queue. A waiting result holds up
// only the next last byte; the input stalls once the queue fills behind it.
module format_string_feature_scanner_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input logic         clk,
  input logic         rst_n,
  fsfs_in_if.sink     in_ch,
  fsfs_out_if.source  out_res
);

  fsfs_pkg::char_class_t front_cls;
  fsfs_pkg::char_class_t back_cls;
  logic                  q_full, q_empty, q_pop;

  fsfs_front u_front (
    .format_char (in_ch.format_char),
    .is_last     (in_ch.is_last),
    .cls         (front_cls)
  );

  assign in_ch.ready = !q_full;

  fsfs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_ch.valid),
    .push_data (front_cls),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (back_cls),
    .empty     (q_empty)
  );

  fsfs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (!q_empty),
    .cls        (back_cls),
    .item_pop   (q_pop),
    .res_valid  (out_res.valid),
    .res_ready  (out_res.ready),
    .res_mask   (out_res.option_mask),
    .res_level  (out_res.level)
  );

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the format string feature scanner top level.
module tb_top;

  localparam int STALL_PCT   = 33;
  localparam int WATCH_LIMIT = 1000;
  localparam int DRAIN_WAIT  = 8;

  typedef logic [7:0] char_q_t[$];

  typedef struct packed {
    logic [31:0] option_mask;
    logic [1:0]  level;
  } scan_result_t;

  typedef struct packed {
    bit          hit;
    logic [1:0]  lvl;
    logic [31:0] short_m;
    logic [31:0] long_m;
  } conv_info_t;

  logic clk;
  logic rst_n;

  fsfs_in_if  in_ch ();
  fsfs_out_if out_res ();

  format_string_feature_scanner_top i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_res (out_res)
  );

  string flag_set = "-0+ *.";
  string conv_set = "duxXonipBscaAeEfFgG";

  logic [fsfs_pkg::MODE_W-1:0] spec_mode = fsfs_pkg::MODE_IDLE;
  logic [31:0]                 seen_mask = '0;
  logic [1:0]                  min_level = fsfs_pkg::LEVEL_MINI;
  scan_result_t                awaited_results[$];

  int  failures   = 0;
  int  bytes_sent = 0;
  int  idle_count = 0;
  bit  no_stall   = 1'b0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Conversion letter table of the scanner.
  function automatic conv_info_t conversion_of(input logic [7:0] c);
    conv_info_t e;
    e = '{hit: 1'b1, lvl: 2'd0, short_m: 32'h0, long_m: 32'h0};
    case (c)
      "d": begin e.lvl = 2'd1; e.short_m = 32'h0000_0001; e.long_m = 32'h0000_1000; end
      "u": begin e.lvl = 2'd1; e.short_m = 32'h0000_0002; e.long_m = 32'h0000_2000; end
      "x": begin e.lvl = 2'd2; e.short_m = 32'h0000_0004; e.long_m = 32'h0000_4000; end
      "X": begin e.lvl = 2'd2; e.short_m = 32'h0000_0008; e.long_m = 32'h0000_8000; end
      "o": begin e.lvl = 2'd2; e.short_m = 32'h0000_0010; e.long_m = 32'h0001_0000; end
      "n": begin e.lvl = 2'd2; e.short_m = 32'h0000_0020; e.long_m = 32'h0002_0000; end
      "i": begin e.lvl = 2'd2; e.short_m = 32'h0000_0040; e.long_m = 32'h0004_0000; end
      "p": begin e.lvl = 2'd2; e.short_m = 32'h0000_0080; e.long_m = 32'h0008_0000; end
      "B": begin e.lvl = 2'd2; e.short_m = 32'h0000_0100; e.long_m = 32'h0010_0000; end
      "s": begin e.lvl = 2'd1; e.short_m = 32'h0000_0200; end
      "c": begin e.lvl = 2'd1; e.short_m = 32'h0000_0400; end
      "a": begin e.lvl = 2'd0; e.short_m = 32'h0040_0000; end
      "A": begin e.lvl = 2'd0; e.short_m = 32'h0080_0000; end
      "e": begin e.lvl = 2'd3; e.short_m = 32'h0100_0000; e.long_m = 32'h0100_0000; end
      "E": begin e.lvl = 2'd3; e.short_m = 32'h0200_0000; e.long_m = 32'h0200_0000; end
      "f": begin e.lvl = 2'd3; e.short_m = 32'h0400_0000; e.long_m = 32'h0400_0000; end
      "F": begin e.lvl = 2'd3; e.short_m = 32'h0800_0000; e.long_m = 32'h0800_0000; end
      "g": begin e.lvl = 2'd3; e.short_m = 32'h1000_0000; e.long_m = 32'h1000_0000; end
      "G": begin e.lvl = 2'd3; e.short_m = 32'h2000_0000; e.long_m = 32'h2000_0000; end
      default: e.hit = 1'b0;
    endcase
    return e;
  endfunction

  function automatic bit is_digit_char(input logic [7:0] c);
    return c >= fsfs_pkg::CHR_ZERO && c <= fsfs_pkg::CHR_NINE;
  endfunction

  task automatic raise_level(input logic [1:0] lvl);
    if (min_level < lvl) begin
      min_level = lvl;
    end
  endtask

  task automatic at_conversion(input logic [7:0] c, input bit long_form);
    conv_info_t e;
    e = conversion_of(c);
    if (e.hit) begin
      raise_level(e.lvl);
      seen_mask |= long_form ? e.long_m : e.short_m;
    end
    spec_mode = (c == fsfs_pkg::CHR_PCT) ? fsfs_pkg::MODE_PCT : fsfs_pkg::MODE_IDLE;
  endtask

  task automatic at_length(input logic [7:0] c);
    if (c == fsfs_pkg::CHR_ELL) begin
      raise_level(fsfs_pkg::LEVEL_STD);
      spec_mode = fsfs_pkg::MODE_LONG;
    end else begin
      at_conversion(c, 1'b0);
    end
  endtask

  // Advances the expected scanner state by one transferred byte.
  task automatic absorb_byte(input logic [7:0] c, input logic last);
    bit is_flag;
    bit is_letter;
    is_flag = c == fsfs_pkg::CHR_MINUS || c == fsfs_pkg::CHR_ZERO ||
              c == fsfs_pkg::CHR_PLUS || c == fsfs_pkg::CHR_SPACE ||
              c == fsfs_pkg::CHR_STAR || c == fsfs_pkg::CHR_DOT;
    is_letter = (c >= fsfs_pkg::CHR_UC_A && c <= fsfs_pkg::CHR_UC_Z) ||
                (c >= fsfs_pkg::CHR_LC_A && c <= fsfs_pkg::CHR_LC_Z);
    case (spec_mode)
      fsfs_pkg::MODE_PCT: begin
        if (is_flag) begin
          raise_level(fsfs_pkg::LEVEL_STD);
          seen_mask |= fsfs_pkg::WIDTH_BIT;
          spec_mode = fsfs_pkg::MODE_FLAGS;
        end else if (is_digit_char(c)) begin
          raise_level(fsfs_pkg::LEVEL_STD);
          seen_mask |= fsfs_pkg::WIDTH_BIT;
          spec_mode = fsfs_pkg::MODE_DIGITS;
        end else begin
          at_length(c);
        end
      end
      fsfs_pkg::MODE_FLAGS: begin
        if (is_letter) begin
          at_length(c);
        end
      end
      fsfs_pkg::MODE_DIGITS: begin
        if (!(is_digit_char(c) || c == fsfs_pkg::CHR_DOT)) begin
          at_length(c);
        end
      end
      fsfs_pkg::MODE_LONG: at_conversion(c, 1'b1);
      default: spec_mode = (c == fsfs_pkg::CHR_PCT) ? fsfs_pkg::MODE_PCT : fsfs_pkg::MODE_IDLE;
    endcase
    if (last) begin
      awaited_results.push_back('{option_mask: seen_mask, level: min_level});
      spec_mode = fsfs_pkg::MODE_IDLE;
      seen_mask = '0;
      min_level = fsfs_pkg::LEVEL_MINI;
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_byte(input logic [7:0] c, input logic last);
    while (!no_stall && $urandom_range(99) < STALL_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.format_char <= c;
    in_ch.is_last     <= last;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    absorb_byte(c, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_bytes(input char_q_t text);
    for (int i = 0; i < text.size(); i++) begin
      send_byte(text[i], i == text.size() - 1);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], i == s.len() - 1);
    end
  endtask

  task automatic test_flags_and_width();
    send_text("%-5d");
    send_text("%1.f");
    send_text("%+");
  endtask

  task automatic test_percent_and_long();
    send_text("%%x");
    send_text("%llx");
    send_text("%lG");
    send_text("%q");
    send_text("%a");
  endtask

  task automatic test_byte_extremes();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(fsfs_pkg::CHR_PCT, 1'b0);
    send_byte(fsfs_pkg::CHR_STAR, 1'b0);
    send_byte(8'hC1, 1'b1);
  endtask

  // Mostly well-formed specifiers with random content, some cut short.
  task automatic test_random_specifiers(input int upto);
    char_q_t text;
    int      segs;
    while (bytes_sent < upto) begin
      text.delete();
      segs = $urandom_range(1, 6);
      for (int k = 0; k < segs; k++) begin
        if ($urandom_range(3) == 0) begin
          repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(32, 126)));
        end else begin
          text.push_back(fsfs_pkg::CHR_PCT);
          if ($urandom_range(2) == 0) begin
            repeat ($urandom_range(1, 3)) text.push_back(flag_set[$urandom_range(5)]);
          end
          if ($urandom_range(2) == 0) begin
            repeat ($urandom_range(1, 3)) begin
              text.push_back($urandom_range(5) == 0 ? fsfs_pkg::CHR_DOT :
                             8'(fsfs_pkg::CHR_ZERO + $urandom_range(9)));
            end
          end
          if ($urandom_range(2) == 0) begin
            text.push_back(fsfs_pkg::CHR_ELL);
            if ($urandom_range(7) == 0) text.push_back(fsfs_pkg::CHR_ELL);
          end
          if ($urandom_range(7) == 0) begin
            text.push_back(8'($urandom_range(255)));
          end else begin
            text.push_back(conv_set[$urandom_range(18)]);
          end
        end
      end
      if ($urandom_range(4) == 0) begin
        text = text[0:$urandom_range(text.size() - 1)];
      end
      send_bytes(text);
    end
  endtask

  task automatic test_back_to_back(input int upto);
    no_stall = 1'b1;
    test_random_specifiers(upto);
    no_stall = 1'b0;
  endtask

  task automatic test_random_bytes(input int upto);
    logic [7:0] c;
    while (bytes_sent < upto) begin
      c = ($urandom_range(3) == 0) ? fsfs_pkg::CHR_PCT : 8'($urandom_range(255));
      send_byte(c, $urandom_range(7) == 0);
    end
    send_byte(8'($urandom_range(255)), 1'b1);
  endtask

  always @(negedge clk) begin
    if (rst_n) begin
      out_res.ready <= no_stall || ($urandom_range(99) >= STALL_PCT);
    end
  end

  always @(posedge clk) begin : result_check
    scan_result_t want;
    if (rst_n && out_res.valid && out_res.ready) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result: option_mask %h level %0d", out_res.option_mask,
               out_res.level);
        failures++;
      end else begin
        want = awaited_results.pop_front();
        if (out_res.option_mask !== want.option_mask) begin
          $error("option_mask expected %h actual %h", want.option_mask, out_res.option_mask);
          failures++;
        end
        if (out_res.level !== want.level) begin
          $error("level expected %0d actual %0d", want.level, out_res.level);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_res.valid && out_res.ready)) begin
        idle_count <= 0;
      end else if (idle_count >= WATCH_LIMIT) begin
        $display("** format_string_feature_scanner_top: FAILED **");
        $finish;
      end else begin
        idle_count <= idle_count + 1;
      end
    end
  end

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.format_char = 8'h00;
    in_ch.is_last     = 1'b0;
    out_res.ready     = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    test_flags_and_width();
    test_percent_and_long();
    test_byte_extremes();
    test_random_specifiers(450);
    test_back_to_back(800);
    test_random_specifiers(1050);
    test_random_bytes(1250);
    in_ch.valid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (failures == 0) begin
      $display("** format_string_feature_scanner_top: PASSED **");
    end else begin
      $display("** format_string_feature_scanner_top: FAILED **");
    end
    $finish;
  end

endmodule
